[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain implication, checked at every rising edge outside reset
`define BCOMP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition in one cycle implies a condition in the next
`define BCOMP_ASSERT_NEXT(lbl, clk, rst, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("assertion failed");

`endif

[sv/bcomp_pkg.sv]
// types, constants and helpers of the barometric compensation block
`timescale 1ns / 1ps
`default_nettype none
package bcomp_pkg;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned PRESS_W  = 19;
  localparam int unsigned OSS_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_BITS_DEF = 4;

  localparam logic [WORD_W-1:0] B6_OFFSET  = 32'd4000;
  localparam logic [WORD_W-1:0] B7_SCALE   = 32'd50000;
  localparam logic [WORD_W-1:0] B4_BIAS    = 32'd32768;
  localparam logic [WORD_W-1:0] P_C1       = 32'd3038;
  localparam logic [WORD_W-1:0] P_C2       = 32'd7357;
  localparam logic [WORD_W-1:0] P_C3       = 32'd3791;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } cfg_idx_t;

  // sideband along the temperature divider
  typedef struct packed {
    logic [WORD_W-1:0]  x1;
    logic [PRESS_W-1:0] up;
    logic               fault;
    logic               neg;
  } t_side_t;

  // sideband along the pressure divider
  typedef struct packed {
    logic [WORD_W-1:0] temp;
    logic              fault;
    logic              big;
  } p_side_t;

  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] dq;
  } div_st_t;

  function automatic logic [WORD_W-1:0] sx16(input logic [HALF_W-1:0] h);
    sx16 = {{HALF_W{h[HALF_W-1]}}, h};
  endfunction

  function automatic logic [WORD_W-1:0] asr(input logic [WORD_W-1:0] v,
                                            input int unsigned s);
    asr = WORD_W'($signed(v) >>> s);
  endfunction

  // one restoring division step: next dividend bit in, one quotient bit out
  function automatic div_st_t div_bit(input div_st_t st, input logic [WORD_W-1:0] dvs);
    logic [WORD_W:0] r;
    logic [WORD_W:0] d;
    div_st_t o;
    r = {st.rem, st.dq[WORD_W-1]};
    o.dq = {st.dq[WORD_W-2:0], 1'b0};
    d = r - {1'b0, dvs};
    if (r >= {1'b0, dvs}) begin
      o.rem = d[WORD_W-1:0];
      o.dq[0] = 1'b1;
    end else begin
      o.rem = r[WORD_W-1:0];
    end
    div_bit = o;
  endfunction
endpackage
`default_nettype wire

[sv/bcomp_if.sv]
// request channels of the compensation block
`timescale 1ns / 1ps
`default_nettype none
interface bcomp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temp;
  logic [18:0] raw_press;
  modport source (output valid, raw_temp, raw_press, input ready);
  modport sink (input valid, raw_temp, raw_press, output ready);
endinterface

interface bcomp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temp_decideg;
  logic [31:0] press_pa;
  logic        div_fault;
  modport source (output valid, temp_decideg, press_pa, div_fault, input ready);
  modport sink (input valid, temp_decideg, press_pa, div_fault, output ready);
endinterface
`default_nettype wire

[sv/baro_temp_pressure_compensation.sv]
// top level: pipelined temperature and pressure compensation
// Takes one raw temperature/pressure request per clock (the whole pipeline
// holds when the output register is full and not taken) and returns the
// compensated temperature (0.1 degC), pressure (Pa) and a divide fault flag.
// At the default of 4 quotient bits per divider stage the pipeline is two
// 8-stage dividers plus 11 arithmetic and output stages. The calibration
// registers must be written only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module baro_temp_pressure_compensation #(
  parameter int unsigned DIV_BITS = bcomp_pkg::DIV_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  bcomp_in_if.sink                         sample,
  bcomp_out_if.source                      result,
  input  wire logic                        cfg_we,
  input  wire logic [bcomp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bcomp_pkg::WORD_W-1:0] cfg_data
);
  import bcomp_pkg::*;

  // calibration registers
  logic [WORD_W-1:0] r_ac12, r_ac34, r_ac56, r_b12, r_mcmd;
  logic [OSS_W-1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_ac12 <= '0;
      r_ac34 <= '0;
      r_ac56 <= '0;
      r_b12  <= '0;
      r_mcmd <= '0;
      oss    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AC1_AC2: r_ac12 <= cfg_data;
        REG_AC3_AC4: r_ac34 <= cfg_data;
        REG_AC5_AC6: r_ac56 <= cfg_data;
        REG_B1_B2:   r_b12  <= cfg_data;
        REG_MC_MD:   r_mcmd <= cfg_data;
        REG_OSS:     oss    <= cfg_data[OSS_W-1:0];
        default: ;
      endcase
    end
  end

  // unpacked coefficients
  logic [WORD_W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(r_ac12[31:16]);
  assign ac2 = sx16(r_ac12[15:0]);
  assign ac3 = sx16(r_ac34[31:16]);
  assign ac4 = {16'd0, r_ac34[15:0]};
  assign ac5 = {16'd0, r_ac56[31:16]};
  assign ac6 = {16'd0, r_ac56[15:0]};
  assign b1  = sx16(r_b12[31:16]);
  assign b2  = sx16(r_b12[15:0]);
  assign mc  = sx16(r_mcmd[31:16]);
  assign md  = sx16(r_mcmd[15:0]);

  // global advance: everything moves when the output slot frees up
  logic adv;
  assign adv = !result.valid || result.ready;
  assign sample.ready = adv;

  // stage a: capture request
  logic               va;
  logic [TEMP_W-1:0]  a_ut;
  logic [PRESS_W-1:0] a_up;
  // stage b: temperature product
  logic               vb;
  logic [WORD_W-1:0]  b_prod;
  logic [PRESS_W-1:0] b_up;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ut   <= sample.raw_temp;
      a_up   <= sample.raw_press;
      b_prod <= ({16'd0, a_ut} - ac6) * ac5;
      b_up   <= a_up;
    end
  end

  // temperature divider setup
  logic [WORD_W-1:0] t_x1, t_den, t_num, t_dvd, t_dvs;
  t_side_t           t_side_in, t_side_out;
  logic              t_ov;
  logic [WORD_W-1:0] t_q;
  assign t_x1  = asr(b_prod, 15);
  assign t_den = t_x1 + md;
  assign t_num = mc << 11;
  assign t_dvd = t_num[31] ? -t_num : t_num;
  assign t_dvs = t_den[31] ? -t_den : t_den;
  assign t_side_in = '{x1: t_x1, up: b_up, fault: (t_den == '0),
                       neg: t_num[31] ^ t_den[31]};

  bcomp_div #(.DIV_BITS(DIV_BITS), .SIDE_W($bits(t_side_t))) u_tdiv (
    .clk, .rst, .en(adv), .in_valid(vb), .dividend(t_dvd), .divisor(t_dvs),
    .side_in(t_side_in), .out_valid(t_ov), .quotient(t_q), .side_out(t_side_out)
  );

  // stage c: b5, temperature, b6
  logic               vc, c_fault;
  logic [WORD_W-1:0]  c_temp, c_b6;
  logic [PRESS_W-1:0] c_up;
  logic [WORD_W-1:0]  c_b5;
  assign c_b5 = t_side_out.x1 + (t_side_out.neg ? -t_q : t_q);

  // stage d: b6 squared
  logic               vd, d_fault;
  logic [WORD_W-1:0]  d_temp, d_b6, d_sq;
  logic [PRESS_W-1:0] d_up;

  // stage e: four coefficient products
  logic               ve, e_fault;
  logic [WORD_W-1:0]  e_temp, e_mb2, e_mac2, e_mac3, e_mb1;
  logic [PRESS_W-1:0] e_up;
  logic [WORD_W-1:0]  d_b6sq;
  assign d_b6sq = asr(d_sq, 12);

  // stage f: b3 and x3
  logic               vf, f_fault;
  logic [WORD_W-1:0]  f_temp, f_b3, f_x3;
  logic [PRESS_W-1:0] f_up;
  logic [WORD_W-1:0]  e_x3a, e_b3, e_x3b;
  assign e_x3a = asr(e_mb2, 11) + asr(e_mac2, 11);
  assign e_b3  = asr((((ac1 << 2) + e_x3a) << oss) + 32'd2, 2);
  assign e_x3b = asr(asr(e_mac3, 13) + asr(e_mb1, 16) + 32'd2, 2);

  // stage g: b4 product and b7
  logic               vg, g_fault;
  logic [WORD_W-1:0]  g_temp, g_b4p, g_b7;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_fault <= t_side_out.fault;
      c_temp  <= asr(c_b5 + 32'd8, 4);
      c_b6    <= c_b5 - B6_OFFSET;
      c_up    <= t_side_out.up;

      d_fault <= c_fault;
      d_temp  <= c_temp;
      d_b6    <= c_b6;
      d_sq    <= c_b6 * c_b6;
      d_up    <= c_up;

      e_fault <= d_fault;
      e_temp  <= d_temp;
      e_mb2   <= b2 * d_b6sq;
      e_mac2  <= ac2 * d_b6;
      e_mac3  <= ac3 * d_b6;
      e_mb1   <= b1 * d_b6sq;
      e_up    <= d_up;

      f_fault <= e_fault;
      f_temp  <= e_temp;
      f_b3    <= e_b3;
      f_x3    <= e_x3b;
      f_up    <= e_up;

      g_fault <= f_fault;
      g_temp  <= f_temp;
      g_b4p   <= ac4 * (f_x3 + B4_BIAS);
      g_b7    <= ({13'd0, f_up} - f_b3) * (B7_SCALE >> oss);
    end
  end

  // pressure divider setup
  logic [WORD_W-1:0] p_b4, p_dvd, p_q;
  p_side_t           p_side_in, p_side_out;
  logic              p_ov;
  assign p_b4  = g_b4p >> 15;
  assign p_dvd = g_b7[31] ? g_b7 : (g_b7 << 1);
  assign p_side_in = '{temp: g_temp, fault: g_fault || (p_b4 == '0), big: g_b7[31]};

  bcomp_div #(.DIV_BITS(DIV_BITS), .SIDE_W($bits(p_side_t))) u_pdiv (
    .clk, .rst, .en(adv), .in_valid(vg), .dividend(p_dvd), .divisor(p_b4),
    .side_in(p_side_in), .out_valid(p_ov), .quotient(p_q), .side_out(p_side_out)
  );

  // stage h: raw pressure
  logic              vh, h_fault;
  logic [WORD_W-1:0] h_temp, h_p;
  // stage i: square and linear products
  logic              vi, i_fault;
  logic [WORD_W-1:0] i_temp, i_p, i_sq, i_m7;
  logic [WORD_W-1:0] h_a;
  assign h_a = asr(h_p, 8);
  // stage j: scaled square and scaled linear term
  logic              vj, j_fault;
  logic [WORD_W-1:0] j_temp, j_p, j_x1p, j_x2;
  logic [WORD_W-1:0] j_press;
  assign j_press = j_p + asr(asr(j_x1p, 16) + j_x2 + P_C3, 4);

  // output register
  logic [WORD_W-1:0] o_temp, o_press;
  logic              o_fault, o_valid;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_fault <= p_side_out.fault;
      h_temp  <= p_side_out.temp;
      h_p     <= p_side_out.big ? (p_q << 1) : p_q;

      i_fault <= h_fault;
      i_temp  <= h_temp;
      i_p     <= h_p;
      i_sq    <= h_a * h_a;
      i_m7    <= P_C2 * h_p;

      j_fault <= i_fault;
      j_temp  <= i_temp;
      j_p     <= i_p;
      j_x1p   <= i_sq * P_C1;
      j_x2    <= asr(-i_m7, 16);

      o_fault <= j_fault;
      o_temp  <= j_fault ? '0 : j_temp;
      o_press <= j_fault ? '0 : j_press;
    end
  end

  // valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
      vj <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      va <= sample.valid;
      vb <= va;
      vc <= t_ov;
      vd <= vc;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= p_ov;
      vi <= vh;
      vj <= vi;
      o_valid <= vj;
    end
  end

  assign result.valid        = o_valid;
  assign result.temp_decideg = o_temp;
  assign result.press_pa     = o_press;
  assign result.div_fault    = o_fault;

  // checks
  `BCOMP_ASSERT(a_fault_zero, clk, rst,
    (result.valid && result.div_fault) |-> (o_temp == '0 && o_press == '0))
  `BCOMP_ASSERT_NEXT(a_oss_write, clk, rst, (cfg_we && cfg_index == REG_OSS),
    (oss == $past(cfg_data[OSS_W-1:0])))
  `BCOMP_ASSERT_NEXT(a_hold, clk, rst, !adv,
    ($stable(va) && $stable(vg) && $stable(vj) && $stable(o_temp)))
endmodule
`default_nettype wire

[sv/bcomp_div.sv]
// pipelined unsigned 32-bit divider, DIV_BITS quotient bits per stage
`timescale 1ns / 1ps
`default_nettype none
module bcomp_div #(
  parameter int unsigned DIV_BITS = bcomp_pkg::DIV_BITS_DEF,
  parameter int unsigned SIDE_W   = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [bcomp_pkg::WORD_W-1:0] dividend,
  input  wire logic [bcomp_pkg::WORD_W-1:0] divisor,
  input  wire logic [SIDE_W-1:0]         side_in,
  output logic                           out_valid,
  output logic [bcomp_pkg::WORD_W-1:0]   quotient,
  output logic [SIDE_W-1:0]              side_out
);
  import bcomp_pkg::*;
  localparam int unsigned STAGES = WORD_W / DIV_BITS;

  div_st_t           st  [STAGES];
  logic [WORD_W-1:0] dvs [STAGES];
  logic [SIDE_W-1:0] sd  [STAGES];
  logic              vld [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    div_st_t           src;
    div_st_t           st_next;
    logic [WORD_W-1:0] dvs_src;
    logic [SIDE_W-1:0] sd_src;
    logic              v_src;

    // stage input: the request itself or the previous stage
    if (s == 0) begin : g_first
      assign src     = '{rem: '0, dq: dividend};
      assign dvs_src = divisor;
      assign sd_src  = side_in;
      assign v_src   = in_valid;
    end else begin : g_rest
      assign src     = st[s-1];
      assign dvs_src = dvs[s-1];
      assign sd_src  = sd[s-1];
      assign v_src   = vld[s-1];
    end

    // chain of quotient bits for this stage
    always_comb begin
      st_next = src;
      for (int b = 0; b < DIV_BITS; b++) begin
        st_next = div_bit(st_next, dvs_src);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_src;
      end
      if (en) begin
        st[s]  <= st_next;
        dvs[s] <= dvs_src;
        sd[s]  <= sd_src;
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign quotient  = st[STAGES-1].dq;
  assign side_out  = sd[STAGES-1];
endmodule
`default_nettype wire
